>>> design/nfa_set_simulator_defines.svh
// Assertion macros used by the checker file of the NFA set simulator.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef NFA_SET_SIMULATOR_DEFINES_SVH
`define NFA_SET_SIMULATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define NSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define NSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/nss_pkg.sv
// Package of the NFA set simulator: field widths, opcodes, register indexes
// and the packed symbol edge type. Depends on nothing.
`default_nettype none

package nss_pkg;

  localparam int OP_W    = 3;
  localparam int STATE_W = 5;
  localparam int SYM_W   = 8;
  localparam int MASK_W  = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W   = 5;

  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_SYM = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_EPS = 3'd2;
  localparam logic [OP_W-1:0] OP_BEGIN   = 3'd3;
  localparam logic [OP_W-1:0] OP_STEP    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL = 1'd1;

  // One labelled transition as stored in the edge memory.
  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [STATE_W-1:0] dst;
    logic [SYM_W-1:0]   label;
  } edge_t;

endpackage

`default_nettype wire

>>> design/nss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module nss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [$clog2(Depth)-1:0]  waddr_i,
  input  wire logic [Width-1:0]          wdata_i,
  input  wire logic [$clog2(Depth)-1:0]  raddr_i,
  output logic      [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/nfa_set_simulator.sv
// Top level of the NFA set simulator: sequencer, active set, epsilon and
// edge memories (nss_ram), output register. Depends on nss_pkg and nss_ram.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   opcode_i, from_state_i, to_state_i, symbol_i
//   out       output     out_valid_o / out_ready_i accepted_o, active_mask_o, table_full_o
//   cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One item at a time; in_ready_o is high only while the sequencer idles. Clear and unused
// opcodes go straight to the response, an epsilon edge reads and rewrites its row, and a
// symbol edge sweeps the edge memory and is stored if new and the table has room. A step
// sweeps the edge memory, then closes the set, one epsilon row read a cycle, until
// MAX_STATES rows in a row add nothing. Reset clears the active set, the edge count and
// row valid bits (no clearing pass). A stalled result holds the response state.
`default_nettype none

module nfa_set_simulator #(
  parameter int MAX_STATES = 32,
  parameter int MAX_EDGES  = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Item input channel.
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [nss_pkg::OP_W-1:0]           opcode_i,
  input  wire logic [nss_pkg::STATE_W-1:0]        from_state_i,
  input  wire logic [nss_pkg::STATE_W-1:0]        to_state_i,
  input  wire logic [nss_pkg::SYM_W-1:0]          symbol_i,
  // Result output channel.
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    accepted_o,
  output logic      [nss_pkg::MASK_W-1:0]         active_mask_o,
  output logic                                    table_full_o,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [nss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [nss_pkg::CFG_W-1:0]          cfg_data_i
);

  // State index, edge address and edge count widths.
  localparam int SW = $clog2(MAX_STATES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = EW + 1;
  localparam int XW = 7;  // wide enough to compare any 5-bit state with MAX_STATES
  localparam int EDGE_W = $bits(nss_pkg::edge_t);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EPS_RD = 3'd1;
  localparam logic [2:0] S_EPS_WR = 3'd2;
  localparam logic [2:0] S_DUP    = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_CLOSE  = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  // True when a 5-bit state index names a real state.
  function automatic logic in_range(input logic [nss_pkg::STATE_W-1:0] s);
    logic [XW-1:0] sx;
    sx = {{(XW-nss_pkg::STATE_W){1'b0}}, s};
    return sx < XW'(MAX_STATES);
  endfunction

  // Low SW bits of a 5-bit state index.
  function automatic logic [SW-1:0] to_idx(input logic [nss_pkg::STATE_W-1:0] s);
    logic [XW-1:0] sx;
    sx = {{(XW-nss_pkg::STATE_W){1'b0}}, s};
    return sx[SW-1:0];
  endfunction

  // One-hot state mask for a state index.
  function automatic logic [MAX_STATES-1:0] bit_of(input logic [SW-1:0] idx);
    return {{(MAX_STATES-1){1'b0}}, 1'b1} << idx;
  endfunction

  logic [2:0]                    state_q, state_d;
  logic [nss_pkg::STATE_W-1:0]   from_q, from_d, to_q, to_d;
  logic [nss_pkg::SYM_W-1:0]     sym_q, sym_d;
  logic [nss_pkg::STATE_W-1:0]   start_q, start_d, final_q, final_d;
  logic [MAX_STATES-1:0]         active_q, active_d;
  logic [MAX_STATES-1:0]         work_q, work_d;
  logic [MAX_STATES-1:0]         row_vld_q, row_vld_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 iss_q, iss_d;
  logic                          ev_q, ev_d;
  logic                          dup_q, dup_d;
  logic                          full_q, full_d;
  logic [SW-1:0]                 ri_q, ri_d;
  logic                          pr_vld_q, pr_vld_d;
  logic [SW-1:0]                 pr_idx_q, pr_idx_d;
  logic [SW-1:0]                 quiet_q, quiet_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_acc_q, out_acc_d;
  logic [nss_pkg::MASK_W-1:0]    out_mask_q, out_mask_d;
  logic                          out_full_q, out_full_d;

  // Memory ports.
  logic                          eps_we;
  logic [MAX_STATES-1:0]         eps_wdata, eps_rdata;
  logic [SW-1:0]                 eps_raddr;
  logic                          edge_we;
  nss_pkg::edge_t                edge_wdata, edge_rd;
  logic [EDGE_W-1:0]             edge_rdata;

  // Shared datapath signals.
  logic                          edge_fire;
  logic [SW-1:0]                 from_idx, to_idx_w, start_idx, final_idx;
  logic [SW-1:0]                 src_idx, dst_idx, ri_nxt;
  logic                          row_hit;
  logic [MAX_STATES-1:0]         row_or;
  logic [nss_pkg::MASK_W+MAX_STATES-1:0] mask_ext;

  assign from_idx  = to_idx(from_q);
  assign to_idx_w  = to_idx(to_q);
  assign start_idx = to_idx(start_q);
  assign final_idx = to_idx(final_q);
  assign edge_rd   = nss_pkg::edge_t'(edge_rdata);
  assign src_idx   = to_idx(edge_rd.src);
  assign dst_idx   = to_idx(edge_rd.dst);
  assign edge_fire = iss_q < cnt_q;
  assign ri_nxt    = (ri_q == SW'(MAX_STATES - 1)) ? '0 : ri_q + 1'b1;
  assign eps_raddr = (state_q == S_EPS_RD) ? from_idx : ri_q;
  assign mask_ext  = {{nss_pkg::MASK_W{1'b0}}, active_q};

  // The one OR/compare unit of the closure: fold the row that just came back
  // from memory into the working set if its state is active.
  assign row_hit = work_q[pr_idx_q] & row_vld_q[pr_idx_q];
  assign row_or  = work_q | (row_hit ? eps_rdata : '0);

  assign edge_wdata = '{src: from_q, dst: to_q, label: sym_q};
  assign eps_wdata  = (row_vld_q[from_idx] ? eps_rdata : '0) | bit_of(to_idx_w);

  nss_ram #(
    .Width (MAX_STATES),
    .Depth (MAX_STATES)
  ) u_eps_ram (
    .clk_i   (clk_i),
    .we_i    (eps_we),
    .waddr_i (from_idx),
    .wdata_i (eps_wdata),
    .raddr_i (eps_raddr),
    .rdata_o (eps_rdata)
  );

  nss_ram #(
    .Width (EDGE_W),
    .Depth (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (cnt_q[EW-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (iss_q[EW-1:0]),
    .rdata_o (edge_rdata)
  );

  // Configuration registers.
  always_comb begin
    start_d = start_q;
    final_d = final_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nss_pkg::REG_START: start_d = cfg_data_i;
        nss_pkg::REG_FINAL: final_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    from_d      = from_q;
    to_d        = to_q;
    sym_d       = sym_q;
    active_d    = active_q;
    work_d      = work_q;
    row_vld_d   = row_vld_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    ev_d        = ev_q;
    dup_d       = dup_q;
    full_d      = full_q;
    ri_d        = ri_q;
    pr_vld_d    = pr_vld_q;
    pr_idx_d    = pr_idx_q;
    quiet_d     = quiet_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_mask_d  = out_mask_q;
    out_full_d  = out_full_q;
    eps_we      = 1'b0;
    edge_we     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          from_d = from_state_i;
          to_d   = to_state_i;
          sym_d  = symbol_i;
          full_d = 1'b0;
          iss_d  = '0;
          ev_d   = 1'b0;
          dup_d  = 1'b0;
          ri_d   = '0;
          pr_vld_d = 1'b0;
          quiet_d  = '0;
          state_d  = S_RESP;
          case (opcode_i)
            nss_pkg::OP_CLEAR: begin
              // The active set survives a clear.
              cnt_d     = '0;
              row_vld_d = '0;
            end
            nss_pkg::OP_ADD_SYM: begin
              if (in_range(from_state_i) && in_range(to_state_i)) begin
                state_d = S_DUP;
              end
            end
            nss_pkg::OP_ADD_EPS: begin
              if (in_range(from_state_i) && in_range(to_state_i)) begin
                state_d = S_EPS_RD;
              end
            end
            nss_pkg::OP_BEGIN: begin
              work_d  = in_range(start_q) ? bit_of(start_idx) : '0;
              state_d = S_CLOSE;
            end
            nss_pkg::OP_STEP: begin
              work_d  = '0;
              state_d = S_MOVE;
            end
            default: ;
          endcase
        end
      end

      S_EPS_RD: begin
        state_d = S_EPS_WR;
      end

      S_EPS_WR: begin
        eps_we              = 1'b1;
        row_vld_d[from_idx] = 1'b1;
        state_d             = S_RESP;
      end

      S_DUP: begin
        iss_d = edge_fire ? iss_q + 1'b1 : iss_q;
        ev_d  = edge_fire;
        if (ev_q && edge_rd == edge_wdata) begin
          dup_d = 1'b1;
        end
        if (!edge_fire && !ev_q) begin
          if (!dup_q) begin
            if (cnt_q >= CW'(MAX_EDGES)) begin
              full_d = 1'b1;
            end else begin
              edge_we = 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end
          end
          state_d = S_RESP;
        end
      end

      S_MOVE: begin
        iss_d = edge_fire ? iss_q + 1'b1 : iss_q;
        ev_d  = edge_fire;
        if (ev_q && edge_rd.label == sym_q && active_q[src_idx]) begin
          work_d = work_q | bit_of(dst_idx);
        end
        if (!edge_fire && !ev_q) begin
          state_d = S_CLOSE;
        end
      end

      S_CLOSE: begin
        ri_d     = ri_nxt;
        pr_vld_d = 1'b1;
        pr_idx_d = ri_q;
        if (pr_vld_q) begin
          work_d = row_or;
          if (row_or != work_q) begin
            quiet_d = '0;
          end else if (quiet_q == SW'(MAX_STATES - 1)) begin
            active_d = work_q;
            pr_vld_d = 1'b0;
            state_d  = S_RESP;
          end else begin
            quiet_d = quiet_q + 1'b1;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = in_range(final_q) && active_q[final_idx];
          out_mask_d  = mask_ext[nss_pkg::MASK_W-1:0];
          out_full_d  = full_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      from_q      <= '0;
      to_q        <= '0;
      sym_q       <= '0;
      start_q     <= '0;
      final_q     <= 5'd31;
      active_q    <= '0;
      work_q      <= '0;
      row_vld_q   <= '0;
      cnt_q       <= '0;
      iss_q       <= '0;
      ev_q        <= 1'b0;
      dup_q       <= 1'b0;
      full_q      <= 1'b0;
      ri_q        <= '0;
      pr_vld_q    <= 1'b0;
      pr_idx_q    <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_mask_q  <= '0;
      out_full_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_q      <= from_d;
      to_q        <= to_d;
      sym_q       <= sym_d;
      start_q     <= start_d;
      final_q     <= final_d;
      active_q    <= active_d;
      work_q      <= work_d;
      row_vld_q   <= row_vld_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      ev_q        <= ev_d;
      dup_q       <= dup_d;
      full_q      <= full_d;
      ri_q        <= ri_d;
      pr_vld_q    <= pr_vld_d;
      pr_idx_q    <= pr_idx_d;
      quiet_q     <= quiet_d;
      out_valid_q <= out_valid_d;
      out_acc_q   <= out_acc_d;
      out_mask_q  <= out_mask_d;
      out_full_q  <= out_full_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_acc_q;
  assign active_mask_o = out_mask_q;
  assign table_full_o  = out_full_q;

endmodule

`default_nettype wire

>>> design/nss_checker.sv
// Port-level checker of the NFA set simulator and its bind to the top level.
// Depends on nss_pkg and nfa_set_simulator_defines.svh.
`default_nettype none
`include "nfa_set_simulator_defines.svh"

module nss_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          accepted_o,
  input wire logic [nss_pkg::MASK_W-1:0]    active_mask_o,
  input wire logic                          table_full_o
);

  // A stalled result keeps its value.
  `NSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(active_mask_o) && $stable(accepted_o) && $stable(table_full_o), "result changed while stalled")

  // The block works on one item at a time.
  `NSS_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "ready right after an accepted item")

  // Acceptance means the final state is in the reported set.
  `NSS_ASSERT_NOW(a_acc_mask, out_valid_o && accepted_o, active_mask_o != '0, "accepted with an empty set")

endmodule

bind nfa_set_simulator nss_checker u_nss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .accepted_o    (accepted_o),
  .active_mask_o (active_mask_o),
  .table_full_o  (table_full_o)
);

`default_nettype wire

>>> bench/nfa_set_simulator_tb.sv
// Self-checking bench for the NFA set simulator: directed automata, random automata and
// random text, with a bit-level predictor of the active set. Depends on nss_pkg and the
// nfa_set_simulator RTL.
`default_nettype none

module nfa_set_simulator_tb;
  import nss_pkg::*;

  localparam int NUM_STATES = 32;
  localparam int EDGE_SLOTS = 64;
  // Item counts at which the random part hands over to the steady tail and then stops.
  localparam int RANDOM_UNTIL = 1200;
  localparam int STEADY_UNTIL = 1370;
  // The run limit covers every item at its slowest (a step with a slow epsilon closure),
  // with the longest gaps and stalls, several times over.
  localparam longint RUN_LIMIT = 100_000_000;

  // One expected result of the block.
  typedef struct packed {
    logic              accepted;
    logic [MASK_W-1:0] mask;
    logic              full;
  } nfa_answer_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OP_W-1:0]      opcode_i;
  logic [STATE_W-1:0]   from_state_i;
  logic [STATE_W-1:0]   to_state_i;
  logic [SYM_W-1:0]     symbol_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 accepted_o;
  logic [MASK_W-1:0]    active_mask_o;
  logic                 table_full_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // Predicted state of the automaton, kept in step with the items as they are sent.
  edge_t              stored_edges [EDGE_SLOTS];
  int                 edge_total;
  logic [MASK_W-1:0]  eps_row [NUM_STATES];
  logic [MASK_W-1:0]  live_set;
  logic [STATE_W-1:0] start_reg;
  logic [STATE_W-1:0] final_reg;

  // Expected results in the order the items were sent.
  nfa_answer_t answers_due [$];
  int          fail_count;
  int          items_sent;
  int          stall_left;
  // When set, neither side idles; the tail of the run keeps it set for good.
  bit          no_idle;
  bit          calm_tail;

  nfa_set_simulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .from_state_i  (from_state_i),
    .to_state_i    (to_state_i),
    .symbol_i      (symbol_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .active_mask_o (active_mask_o),
    .table_full_o  (table_full_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Grows a set by epsilon successors until it stops changing.
  function automatic logic [MASK_W-1:0] grow_by_eps(input logic [MASK_W-1:0] seed);
    logic [MASK_W-1:0] grown;
    logic [MASK_W-1:0] prior;
    grown = seed;
    do begin
      prior = grown;
      for (int i = 0; i < NUM_STATES; i++)
        if (grown[i]) grown |= eps_row[i];
    end while (grown != prior);
    return grown;
  endfunction

  // Targets of every stored edge labelled with the byte that leaves an active state.
  function automatic logic [MASK_W-1:0] symbol_successors(input logic [MASK_W-1:0] from_set,
                                                          input logic [SYM_W-1:0] text_byte);
    logic [MASK_W-1:0] reached;
    reached = '0;
    for (int k = 0; k < edge_total; k++)
      if (stored_edges[k].label == text_byte && from_set[stored_edges[k].src])
        reached[stored_edges[k].dst] = 1'b1;
    return reached;
  endfunction

  // Applies one item to the predicted automaton and returns the result it must produce.
  function automatic nfa_answer_t next_answer(input logic [OP_W-1:0] op,
                                              input logic [STATE_W-1:0] from_s,
                                              input logic [STATE_W-1:0] to_s,
                                              input logic [SYM_W-1:0] sym);
    nfa_answer_t ans;
    edge_t       probe;
    logic        dup;
    ans.full = 1'b0;
    probe = '{src: from_s, dst: to_s, label: sym};
    case (op)
      OP_CLEAR: begin
        // The active set survives a clear; only the tables go.
        edge_total = 0;
        for (int i = 0; i < NUM_STATES; i++) eps_row[i] = '0;
      end
      OP_ADD_SYM: begin
        // Edges form a set, so a duplicate is neither stored nor flagged.
        dup = 1'b0;
        for (int k = 0; k < edge_total; k++)
          if (stored_edges[k] == probe) dup = 1'b1;
        if (!dup) begin
          if (edge_total >= EDGE_SLOTS) begin
            ans.full = 1'b1;
          end else begin
            stored_edges[edge_total] = probe;
            edge_total++;
          end
        end
      end
      OP_ADD_EPS: eps_row[from_s][to_s] = 1'b1;
      OP_BEGIN:   live_set = grow_by_eps(MASK_W'(1) << start_reg);
      OP_STEP:    live_set = grow_by_eps(symbol_successors(live_set, sym));
      default: ;
    endcase
    ans.mask = live_set;
    ans.accepted = live_set[final_reg];
    return ans;
  endfunction

  function automatic logic [STATE_W-1:0] rand_state();
    return STATE_W'($urandom);
  endfunction

  function automatic logic [SYM_W-1:0] rand_sym();
    return SYM_W'($urandom);
  endfunction

  function automatic logic [STATE_W-1:0] pick_state(input int base, input int span);
    return STATE_W'(base + $urandom_range(0, span - 1));
  endfunction

  // Offers one item, possibly after a random gap, and holds it until it is accepted.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [STATE_W-1:0] from_s,
                           input logic [STATE_W-1:0] to_s, input logic [SYM_W-1:0] sym);
    if (!no_idle && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    answers_due.push_back(next_answer(op, from_s, to_s, sym));
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    from_state_i <= from_s;
    to_state_i   <= to_s;
    symbol_i     <= sym;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    items_sent++;
  endtask

  // Every item returns a result, so the block is idle once all results are back.
  task automatic wait_drained();
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_START) start_reg = val;
    else final_reg = val;
  endtask

  // Hand-built automata: both extreme states, the extreme bytes, every opcode, a duplicate
  // edge, an epsilon self loop and cycle, a clear that keeps the active set, and the
  // unused opcodes.
  task automatic test_directed();
    logic [OP_W-1:0] spare_op;
    send_item(OP_STEP, '0, '0, 8'h00);
    send_item(OP_BEGIN, '0, '0, 8'h00);
    send_item(OP_ADD_SYM, 5'd0, 5'd31, 8'h00);
    send_item(OP_ADD_SYM, 5'd0, 5'd1, 8'hFF);
    send_item(OP_ADD_SYM, 5'd0, 5'd31, 8'h00);
    send_item(OP_ADD_EPS, 5'd31, 5'd30, 8'hFF);
    send_item(OP_ADD_EPS, 5'd1, 5'd31, 8'h00);
    send_item(OP_ADD_EPS, 5'd30, 5'd30, 8'h00);
    send_item(OP_BEGIN, '1, '1, 8'hFF);
    send_item(OP_STEP, '0, '0, 8'h00);
    send_item(OP_BEGIN, '0, '0, 8'h00);
    send_item(OP_STEP, '0, '0, 8'hFF);
    send_item(OP_STEP, '1, '1, 8'hFF);
    for (int k = 1; k <= 3; k++) begin
      spare_op = OP_STEP + OP_W'(k);
      send_item(spare_op, '1, '1, 8'hFF);
    end
    send_item(OP_BEGIN, '0, '0, 8'h00);
    send_item(OP_CLEAR, '1, '1, 8'hFF);
    send_item(OP_STEP, '0, '0, 8'h00);
    // Swap the start and final states to the opposite extremes.
    write_reg(REG_START, 5'd31);
    write_reg(REG_FINAL, 5'd0);
    send_item(OP_ADD_EPS, 5'd31, 5'd0, 8'h55);
    send_item(OP_ADD_EPS, 5'd0, 5'd31, 8'hAA);
    send_item(OP_ADD_SYM, 5'd31, 5'd31, 8'hAA);
    send_item(OP_BEGIN, '0, '0, 8'h00);
    send_item(OP_STEP, '0, '0, 8'hAA);
    send_item(OP_STEP, '0, '0, 8'h55);
  endtask

  // One random automaton: new registers at random, a fresh table over a small alphabet and a few
  // strings run through it, with stray items mixed in. A dense automaton overruns the
  // edge table so that dropped edges are flagged.
  task automatic run_phase();
    logic [SYM_W-1:0] alphabet [4];
    logic [OP_W-1:0]  spare_op;
    int               base;
    int               span;
    int               n_letters;
    int               n_sym;
    int               n_eps;
    bit               dense;
    no_idle = calm_tail || ($urandom_range(0, 4) == 0);
    dense = ($urandom_range(0, 5) == 0);
    span = dense || ($urandom_range(0, 3) == 0) ? NUM_STATES
         : ($urandom_range(0, 1) != 0 ? 8 : 4);
    base = $urandom_range(0, NUM_STATES - span);
    n_letters = dense ? 4 : $urandom_range(2, 4);
    foreach (alphabet[a]) alphabet[a] = rand_sym();
    if ($urandom_range(0, 4) == 0) alphabet[0] = '0;
    if ($urandom_range(0, 4) == 0) alphabet[1] = '1;

    // Registers are written here with the block idle; the extremes come up often.
    if ($urandom_range(0, 2) != 0)
      write_reg(REG_START, $urandom_range(0, 4) == 0 ? '0
                         : ($urandom_range(0, 3) == 0 ? '1 : pick_state(base, span)));
    if ($urandom_range(0, 2) != 0)
      write_reg(REG_FINAL, $urandom_range(0, 4) == 0 ? '0
                         : ($urandom_range(0, 3) == 0 ? '1 : pick_state(base, span)));

    send_item(OP_CLEAR, rand_state(), rand_state(), rand_sym());
    n_sym = dense ? $urandom_range(66, 80) : $urandom_range(2, 14);
    n_eps = $urandom_range(0, 5);
    while (n_sym + n_eps > 0) begin
      if (n_eps > 0 && $urandom_range(0, n_sym + n_eps - 1) < n_eps) begin
        send_item(OP_ADD_EPS, pick_state(base, span), pick_state(base, span), rand_sym());
        n_eps--;
      end else begin
        send_item(OP_ADD_SYM, pick_state(base, span), pick_state(base, span),
                  alphabet[$urandom_range(0, n_letters - 1)]);
        n_sym--;
      end
    end

    repeat ($urandom_range(2, 5)) begin
      send_item(OP_BEGIN, rand_state(), rand_state(), rand_sym());
      repeat ($urandom_range(2, 10)) begin
        case ($urandom_range(0, 23))
          0: begin
            spare_op = OP_STEP + OP_W'($urandom_range(1, 3));
            send_item(spare_op, rand_state(), rand_state(), rand_sym());
          end
          1: send_item(OP_ADD_SYM, pick_state(base, span), pick_state(base, span),
                       alphabet[$urandom_range(0, n_letters - 1)]);
          2: send_item(OP_ADD_EPS, pick_state(base, span), pick_state(base, span),
                       rand_sym());
          3: send_item(OP_STEP, rand_state(), rand_state(), rand_sym());
          4: send_item(OP_ADD_SYM, rand_state(), rand_state(), rand_sym());
          default: send_item(OP_STEP, rand_state(), rand_state(),
                             alphabet[$urandom_range(0, n_letters - 1)]);
        endcase
      end
    end
    // Now and then clear mid-string and step on: the set stays but the edges are gone.
    if ($urandom_range(0, 5) == 0) begin
      send_item(OP_CLEAR, rand_state(), rand_state(), rand_sym());
      send_item(OP_STEP, rand_state(), rand_state(), alphabet[0]);
    end
  endtask

  task automatic test_random_automata();
    while (items_sent < RANDOM_UNTIL) run_phase();
  endtask

  // The tail of the run with both sides always ready.
  task automatic test_steady_stream();
    calm_tail = 1'b1;
    while (items_sent < STEADY_UNTIL) run_phase();
  endtask

  // Result side: ready drops in random bursts unless idling is off.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest expected one.
  always @(posedge clk_i) begin : score_results
    nfa_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with none expected: accepted %b mask %h full %b",
                 $time, accepted_o, active_mask_o, table_full_o);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (accepted_o !== want.accepted) begin
          $display("%0t: accepted expected %b, got %b", $time, want.accepted, accepted_o);
          fail_count++;
        end
        if (active_mask_o !== want.mask) begin
          $display("%0t: active_mask expected %h, got %h", $time, want.mask, active_mask_o);
          fail_count++;
        end
        if (table_full_o !== want.full) begin
          $display("%0t: table_full expected %b, got %b", $time, want.full, table_full_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // The predictor starts from the reset state of the block.
    edge_total = 0;
    foreach (eps_row[i]) eps_row[i] = '0;
    live_set     = '0;
    start_reg    = '0;
    final_reg    = '1;
    fail_count   = 0;
    items_sent   = 0;
    stall_left   = 0;
    no_idle      = 1'b0;
    calm_tail    = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_CLEAR;
    from_state_i = '0;
    to_state_i   = '0;
    symbol_i     = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_START;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_automata();
    test_steady_stream();

    // Let the last results come back, then give the block time to show anything extra.
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("nfa_set_simulator: match");
    end else begin
      $display("nfa_set_simulator: mismatch");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(RUN_LIMIT);
    $display("nfa_set_simulator: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
